// File: hdl/fsmgr_pkg.sv
package fsmgr_pkg;

    localparam int SlotCount = 3;
    localparam int SlotW     = (SlotCount > 2) ? 2 : 1;
    localparam int CfgIdxW   = 2;
    localparam int CfgDataW  = 24;

    typedef enum logic [2:0] {
        MODE_RESERVE = 3'd0,
        MODE_COMMIT  = 3'd1,
        MODE_ABORT   = 3'd2,
        MODE_ACQUIRE = 3'd3,
        MODE_LATEST  = 3'd4,
        MODE_RELEASE = 3'd5
    } t_mode;

    typedef enum logic [2:0] {
        STS_OK          = 3'd0,
        STS_BAD_GEOM    = 3'd1,
        STS_NO_SLOT     = 3'd2,
        STS_STALE       = 3'd3,
        STS_INVALID     = 3'd4,
        STS_NOTHING_NEW = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        PH_FREE    = 2'd0,
        PH_WRITING = 2'd1,
        PH_READY   = 2'd2
    } t_phase;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_MAX_WIDTH  = 2'd0,
        CFG_MAX_HEIGHT = 2'd1,
        CFG_MAX_BYTES  = 2'd2
    } t_cfg_reg;

    typedef enum logic {
        CS_IDLE = 1'b0,
        CS_EXEC = 1'b1
    } t_ctrl_state;

    typedef struct packed {
        logic [2:0]  mode;
        logic [1:0]  slot_index;
        logic [31:0] generation;
        logic [31:0] frame_num;
        logic [31:0] capture_time;
        logic [11:0] width;
        logic [11:0] height;
        logic [12:0] stride;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [1:0]  slot_out;
        logic [31:0] generation_out;
        logic [31:0] frame_num_out;
        logic [31:0] capture_time_out;
        logic [11:0] width_out;
        logic [11:0] height_out;
        logic [12:0] stride_out;
        logic [31:0] dropped_total;
        logic [31:0] overwritten_total;
        logic [31:0] submitted_total;
    } t_out_item;

    typedef struct packed {
        logic latch;
        logic exec;
    } t_cmd;

    typedef struct packed {
        logic out_full;
    } t_stat;

endpackage

// File: hdl/fsmgr_ctrl.sv
module fsmgr_ctrl
    import fsmgr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_ctrl_state r_state;
    t_ctrl_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            CS_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = CS_EXEC;
                end
            end
            CS_EXEC: begin
                // hold the finished item until the output register frees up
                if (!i_stat.out_full) begin
                    o_cmd.exec = 1'b1;
                    n_state    = CS_IDLE;
                end
            end
            default: begin
                n_state = CS_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/fsmgr_dp.sv
module fsmgr_dp
    import fsmgr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_index,
    input  logic [CfgDataW-1:0] i_cfg_data,
    input  t_in_item            i_in_data,
    input  t_cmd                i_cmd,
    output t_stat               o_stat,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output t_out_item           o_out_data
);

    t_in_item    r_item;
    logic [11:0] r_max_w;
    logic [11:0] r_max_h;
    logic [23:0] r_max_b;

    t_phase      r_phase   [SlotCount];
    logic [31:0] r_gen     [SlotCount];
    logic [7:0]  r_readers [SlotCount];
    logic [31:0] r_frame   [SlotCount];
    logic [31:0] r_time    [SlotCount];
    logic [11:0] r_geo_w   [SlotCount];
    logic [11:0] r_geo_h   [SlotCount];
    logic [12:0] r_geo_s   [SlotCount];

    t_phase      n_phase   [SlotCount];
    logic [31:0] n_gen     [SlotCount];
    logic [7:0]  n_readers [SlotCount];
    logic [31:0] n_frame   [SlotCount];
    logic [31:0] n_time    [SlotCount];
    logic [11:0] n_geo_w   [SlotCount];
    logic [11:0] n_geo_h   [SlotCount];
    logic [12:0] n_geo_s   [SlotCount];

    logic [SlotW-1:0] r_next_slot,    n_next_slot;
    logic             r_latest_valid, n_latest_valid;
    logic [SlotW-1:0] r_latest_slot,  n_latest_slot;
    logic [31:0]      r_latest_gen,   n_latest_gen;
    logic [31:0]      r_latest_frame, n_latest_frame;
    logic [31:0]      r_drop,         n_drop;
    logic [31:0]      r_over,         n_over;
    logic [31:0]      r_submit,       n_submit;

    logic      r_out_valid;
    t_out_item r_out;
    t_out_item n_out;

    logic [24:0]      bytes;
    logic             geom_bad;
    logic             found;
    logic [SlotW-1:0] sel;
    logic [SlotW:0]   cand;
    logic             idx_ok;
    logic [SlotW-1:0] idx;
    logic             gen_match;
    t_status          status;
    logic             put_full;
    logic             put_short;
    logic [SlotW-1:0] res_slot;

    assign bytes    = 25'(r_item.stride) * 25'(r_item.height);
    assign geom_bad = (r_item.width == '0) || (r_item.height == '0) ||
                      (13'(r_item.width) > r_item.stride) ||
                      (r_item.width > r_max_w) || (r_item.height > r_max_h) ||
                      (bytes > 25'(r_max_b));

    assign idx_ok    = 3'(r_item.slot_index) < 3'(SlotCount);
    assign idx       = r_item.slot_index[SlotW-1:0];
    assign gen_match = r_gen[idx] == r_item.generation;

    // round-robin scan from next_slot: first slot not being written, no readers
    always_comb begin
        found = 1'b0;
        sel   = '0;
        cand  = '0;
        for (int a = 0; a < SlotCount; a++) begin
            cand = {1'b0, r_next_slot} + (SlotW+1)'(a);
            if (cand >= (SlotW+1)'(SlotCount)) begin
                cand = cand - (SlotW+1)'(SlotCount);
            end
            if (!found && r_phase[cand[SlotW-1:0]] != PH_WRITING &&
                r_readers[cand[SlotW-1:0]] == '0) begin
                found = 1'b1;
                sel   = cand[SlotW-1:0];
            end
        end
    end

    always_comb begin
        n_phase        = r_phase;
        n_gen          = r_gen;
        n_readers      = r_readers;
        n_frame        = r_frame;
        n_time         = r_time;
        n_geo_w        = r_geo_w;
        n_geo_h        = r_geo_h;
        n_geo_s        = r_geo_s;
        n_next_slot    = r_next_slot;
        n_latest_valid = r_latest_valid;
        n_latest_slot  = r_latest_slot;
        n_latest_gen   = r_latest_gen;
        n_latest_frame = r_latest_frame;
        n_drop         = r_drop;
        n_over         = r_over;
        n_submit       = r_submit;
        status         = STS_INVALID;
        put_full       = 1'b0;
        put_short      = 1'b0;
        res_slot       = idx;

        unique case (r_item.mode)
            MODE_RESERVE: begin
                if (geom_bad) begin
                    n_drop = r_drop + 32'd1;
                    status = STS_BAD_GEOM;
                end else if (!found) begin
                    n_drop = r_drop + 32'd1;
                    status = STS_NO_SLOT;
                end else begin
                    n_next_slot = (sel == SlotW'(SlotCount - 1)) ? '0 : sel + SlotW'(1);
                    if (r_phase[sel] == PH_READY) begin
                        n_over = r_over + 32'd1;
                    end
                    n_phase[sel] = PH_WRITING;
                    // generation wraps past all ones to 1, never 0
                    n_gen[sel]   = (r_gen[sel] == '1) ? 32'd1 : r_gen[sel] + 32'd1;
                    n_frame[sel] = '0;
                    n_time[sel]  = '0;
                    n_geo_w[sel] = r_item.width;
                    n_geo_h[sel] = r_item.height;
                    n_geo_s[sel] = r_item.stride;
                    status       = STS_OK;
                    put_full     = 1'b1;
                    res_slot     = sel;
                end
            end
            MODE_COMMIT: begin
                if (idx_ok) begin
                    if (r_phase[idx] != PH_WRITING || !gen_match) begin
                        n_drop = r_drop + 32'd1;
                        status = STS_STALE;
                    end else begin
                        n_frame[idx]   = r_item.frame_num;
                        n_time[idx]    = r_item.capture_time;
                        n_phase[idx]   = PH_READY;
                        n_latest_valid = 1'b1;
                        n_latest_slot  = idx;
                        n_latest_gen   = r_gen[idx];
                        n_latest_frame = r_item.frame_num;
                        n_submit       = r_submit + 32'd1;
                        status         = STS_OK;
                        put_full       = 1'b1;
                    end
                end
            end
            MODE_ABORT: begin
                if (idx_ok && r_phase[idx] == PH_WRITING && gen_match) begin
                    n_phase[idx] = PH_FREE;
                    status       = STS_OK;
                    put_short    = 1'b1;
                end
            end
            MODE_ACQUIRE: begin
                if (idx_ok && r_phase[idx] == PH_READY && gen_match) begin
                    if (r_readers[idx] != '1) begin
                        n_readers[idx] = r_readers[idx] + 8'd1;
                    end
                    status   = STS_OK;
                    put_full = 1'b1;
                end
            end
            MODE_LATEST: begin
                if (!r_latest_valid || r_latest_frame == r_item.frame_num) begin
                    status = STS_NOTHING_NEW;
                end else if (r_phase[r_latest_slot] == PH_READY &&
                             r_gen[r_latest_slot] == r_latest_gen) begin
                    if (r_readers[r_latest_slot] != '1) begin
                        n_readers[r_latest_slot] = r_readers[r_latest_slot] + 8'd1;
                    end
                    status   = STS_OK;
                    put_full = 1'b1;
                    res_slot = r_latest_slot;
                end
            end
            MODE_RELEASE: begin
                if (idx_ok && r_readers[idx] != '0) begin
                    n_readers[idx] = r_readers[idx] - 8'd1;
                    status         = STS_OK;
                    put_short      = 1'b1;
                end
            end
            default: begin
                status = STS_INVALID;
            end
        endcase
    end

    // result reflects slot contents after the update
    always_comb begin
        n_out        = '0;
        n_out.status = status;
        if (put_full || put_short) begin
            n_out.slot_out       = 2'(res_slot);
            n_out.generation_out = n_gen[res_slot];
        end
        if (put_full) begin
            n_out.frame_num_out    = n_frame[res_slot];
            n_out.capture_time_out = n_time[res_slot];
            n_out.width_out        = n_geo_w[res_slot];
            n_out.height_out       = n_geo_h[res_slot];
            n_out.stride_out       = n_geo_s[res_slot];
        end
        n_out.dropped_total     = n_drop;
        n_out.overwritten_total = n_over;
        n_out.submitted_total   = n_submit;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_item <= i_in_data;
        end
        if (i_cmd.exec) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_w        <= 12'd640;
            r_max_h        <= 12'd480;
            r_max_b        <= 24'd307200;
            for (int s = 0; s < SlotCount; s++) begin
                r_phase[s]   <= PH_FREE;
                r_gen[s]     <= '0;
                r_readers[s] <= '0;
                r_frame[s]   <= '0;
                r_time[s]    <= '0;
                r_geo_w[s]   <= '0;
                r_geo_h[s]   <= '0;
                r_geo_s[s]   <= '0;
            end
            r_next_slot    <= '0;
            r_latest_valid <= 1'b0;
            r_latest_slot  <= '0;
            r_latest_gen   <= '0;
            r_latest_frame <= '0;
            r_drop         <= '0;
            r_over         <= '0;
            r_submit       <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_MAX_WIDTH:  r_max_w <= i_cfg_data[11:0];
                    CFG_MAX_HEIGHT: r_max_h <= i_cfg_data[11:0];
                    CFG_MAX_BYTES:  r_max_b <= i_cfg_data[23:0];
                    default: ;
                endcase
            end
            if (i_cmd.exec) begin
                r_phase        <= n_phase;
                r_gen          <= n_gen;
                r_readers      <= n_readers;
                r_frame        <= n_frame;
                r_time         <= n_time;
                r_geo_w        <= n_geo_w;
                r_geo_h        <= n_geo_h;
                r_geo_s        <= n_geo_s;
                r_next_slot    <= n_next_slot;
                r_latest_valid <= n_latest_valid;
                r_latest_slot  <= n_latest_slot;
                r_latest_gen   <= n_latest_gen;
                r_latest_frame <= n_latest_frame;
                r_drop         <= n_drop;
                r_over         <= n_over;
                r_submit       <= n_submit;
            end
            if (i_cmd.exec) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.out_full = r_out_valid && !i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out;

endmodule

// File: hdl/frame_slot_manager_top.sv
// Frame slot manager: bookkeeping for a small ring of frame buffers.
// Input channel (i_in_valid / o_in_ready / i_in_data) takes one request:
// reserve, commit, abort, acquire by handle, acquire latest, or release.
// Output channel (o_out_valid / i_out_ready / o_out_data) returns exactly
// one result per request: status, slot handle and contents, and the
// drop / overwrite / submit counters as they stand after the request.
// Limits are set through i_cfg_we / i_cfg_index / i_cfg_data, one write per
// cycle; the user must write them only while no request is in flight (not enforced by the block).
// Timing: a transferred request is latched into the item register and then
// executed; its result is registered in the output register on execute.
// A new request is taken only after the last one has executed (slot scan,
// stride*height check and state update all complete in that step). The
// input is ready again while the result waits in the output register; if
// the receiver still stalls when the next request is ready to execute,
// that request waits until the output frees.
// Reset (synchronous, active low) frees all slots, clears generations,
// reader counts, latest frame and counters, and restores the default limits
// of 640 x 480 and 307200 bytes.
module frame_slot_manager_top
    import fsmgr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_index,
    input  logic [CfgDataW-1:0] i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  t_in_item            i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output t_out_item           o_out_data
);

    t_cmd  cmd;
    t_stat stat;

    fsmgr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    fsmgr_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request taken while another is in flight");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.exec |-> !(o_out_valid && !i_out_ready))
        else $error("result written over a stalled result");

    a_exec_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.exec |=> o_out_valid)
        else $error("executed request produced no result");

    a_exec_after_latch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.exec |-> !cmd.latch)
        else $error("latch and execute in the same cycle");

endmodule

// File: verif/tb_frame_slot_manager_top.sv
module tb_frame_slot_manager_top;
    import fsmgr_pkg::*;

    localparam logic [2:0] MODE_SPARE_A = 3'd6;
    localparam logic [2:0] MODE_SPARE_B = 3'd7;
    localparam int STALL_LIMIT = 1000;
    localparam int DIR_ROWS    = 27;
    localparam int SEGMENTS    = 6;
    localparam int SAT_ACQUIRES = 260;
    localparam int SAT_RELEASES = 258;

    typedef struct {
        t_in_item    req;
        bit          typed;
        t_status     sts;
        logic [1:0]  slot;
        logic [31:0] gen;
        logic [31:0] drops;
    } t_request_row;

    typedef struct {
        int src_pct;
        int snk_pct;
        int max_w;
        int max_h;
        int max_b;
        int items;
        bit saturate;
    } t_segment;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_cfg_we    = 1'b0;
    logic [CfgIdxW-1:0]  i_cfg_index = CFG_MAX_WIDTH;
    logic [CfgDataW-1:0] i_cfg_data  = '0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_ready;
    t_in_item            i_in_data   = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    t_out_item           o_out_data;

    frame_slot_manager_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // frame store as the block should hold it
    t_phase      frm_phase   [SlotCount];
    logic [31:0] frm_gen     [SlotCount];
    logic [7:0]  frm_readers [SlotCount];
    logic [31:0] frm_id      [SlotCount];
    logic [31:0] frm_time    [SlotCount];
    logic [11:0] frm_w       [SlotCount];
    logic [11:0] frm_h       [SlotCount];
    logic [12:0] frm_stride  [SlotCount];
    int          scan_start;
    bit          pub_valid;
    int          pub_slot;
    logic [31:0] pub_gen;
    logic [31:0] pub_frame;
    logic [31:0] n_dropped;
    logic [31:0] n_overwritten;
    logic [31:0] n_submitted;
    logic [11:0] lim_width;
    logic [11:0] lim_height;
    logic [23:0] lim_bytes;

    t_request_row req_q [$];
    t_out_item    pending_results [$];
    t_request_row directed_rows [DIR_ROWS];
    t_segment     segs [SEGMENTS];
    t_request_row cur_row;
    t_out_item    predicted;
    t_out_item    want;
    int           rand_left    = 0;
    int           src_idle_pct = 0;
    int           snk_idle_pct = 0;
    bit           hold_src     = 1'b0;
    int           sat_acq      = 0;
    int           sat_rel      = 0;
    int           sat_slot     = -1;
    int           error_cnt    = 0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_out_item frame_view(int s);
        t_out_item res;
        res = '0;
        res.status           = STS_OK;
        res.slot_out         = 2'(s);
        res.generation_out   = frm_gen[s];
        res.frame_num_out    = frm_id[s];
        res.capture_time_out = frm_time[s];
        res.width_out        = frm_w[s];
        res.height_out       = frm_h[s];
        res.stride_out       = frm_stride[s];
        return res;
    endfunction

    function automatic t_out_item apply_request(t_in_item req);
        t_out_item res;
        int sel;
        int s;
        int ix;
        bit ix_ok;
        res = '0;
        res.status = STS_INVALID;
        ix = int'(req.slot_index);
        ix_ok = ix < SlotCount;
        case (req.mode)
            MODE_RESERVE: begin
                if (req.width == 0 || req.height == 0 || req.stride < req.width
                    || req.width > lim_width || req.height > lim_height
                    || 32'(req.stride) * 32'(req.height) > 32'(lim_bytes)) begin
                    n_dropped++;
                    res.status = STS_BAD_GEOM;
                end else begin
                    sel = -1;
                    // round-robin from the slot after the last one claimed
                    for (int a = 0; a < SlotCount; a++) begin
                        s = (scan_start + a) % SlotCount;
                        if (sel < 0 && frm_phase[s] != PH_WRITING && frm_readers[s] == 0)
                            sel = s;
                    end
                    if (sel < 0) begin
                        n_dropped++;
                        res.status = STS_NO_SLOT;
                    end else begin
                        scan_start = (sel + 1) % SlotCount;
                        if (frm_phase[sel] == PH_READY)
                            n_overwritten++;
                        frm_phase[sel] = PH_WRITING;
                        frm_gen[sel] = (frm_gen[sel] == 32'hFFFF_FFFF) ? 32'd1
                                                                       : frm_gen[sel] + 32'd1;
                        frm_id[sel]     = '0;
                        frm_time[sel]   = '0;
                        frm_w[sel]      = req.width;
                        frm_h[sel]      = req.height;
                        frm_stride[sel] = req.stride;
                        res = frame_view(sel);
                    end
                end
            end
            MODE_COMMIT: begin
                if (ix_ok) begin
                    if (frm_phase[ix] != PH_WRITING || frm_gen[ix] != req.generation) begin
                        n_dropped++;
                        res.status = STS_STALE;
                    end else begin
                        frm_id[ix]    = req.frame_num;
                        frm_time[ix]  = req.capture_time;
                        frm_phase[ix] = PH_READY;
                        pub_valid = 1'b1;
                        pub_slot  = ix;
                        pub_gen   = frm_gen[ix];
                        pub_frame = req.frame_num;
                        n_submitted++;
                        res = frame_view(ix);
                    end
                end
            end
            MODE_ABORT: begin
                if (ix_ok && frm_phase[ix] == PH_WRITING && frm_gen[ix] == req.generation) begin
                    frm_phase[ix] = PH_FREE;
                    res.status = STS_OK;
                    res.slot_out = 2'(ix);
                    res.generation_out = frm_gen[ix];
                end
            end
            MODE_ACQUIRE: begin
                if (ix_ok && frm_phase[ix] == PH_READY && frm_gen[ix] == req.generation) begin
                    if (frm_readers[ix] != 8'hFF)
                        frm_readers[ix]++;
                    res = frame_view(ix);
                end
            end
            MODE_LATEST: begin
                if (!pub_valid || pub_frame == req.frame_num) begin
                    res.status = STS_NOTHING_NEW;
                end else if (frm_phase[pub_slot] == PH_READY
                             && frm_gen[pub_slot] == pub_gen) begin
                    if (frm_readers[pub_slot] != 8'hFF)
                        frm_readers[pub_slot]++;
                    res = frame_view(pub_slot);
                end
            end
            MODE_RELEASE: begin
                if (ix_ok && frm_readers[ix] != 0) begin
                    frm_readers[ix]--;
                    res.status = STS_OK;
                    res.slot_out = 2'(ix);
                    res.generation_out = frm_gen[ix];
                end
            end
            default: ;
        endcase
        res.dropped_total     = n_dropped;
        res.overwritten_total = n_overwritten;
        res.submitted_total   = n_submitted;
        return res;
    endfunction

    // returns a slot in the given phase, or one holding readers; -1 if none
    function automatic int find_slot(t_phase ph, bit need_readers);
        int first;
        int s;
        first = $urandom_range(0, SlotCount - 1);
        for (int a = 0; a < SlotCount; a++) begin
            s = (first + a) % SlotCount;
            if (need_readers ? (frm_readers[s] != 0) : (frm_phase[s] == ph))
                return s;
        end
        return -1;
    endfunction

    // mostly handles that match the current store, the rest noise
    function automatic t_in_item make_request();
        t_in_item req;
        int pick;
        int roll;
        req.mode         = 3'($urandom_range(0, 7));
        req.slot_index   = 2'($urandom_range(0, 3));
        req.generation   = $urandom();
        req.frame_num    = $urandom();
        req.capture_time = $urandom();
        req.width        = 12'($urandom());
        req.height       = 12'($urandom());
        req.stride       = 13'($urandom());
        pick = -1;
        roll = $urandom_range(0, 99);
        if (sat_acq > 0 && (sat_slot >= 0 || find_slot(PH_READY, 1'b0) >= 0)) begin
            if (sat_slot < 0)
                sat_slot = find_slot(PH_READY, 1'b0);
            req.mode = MODE_ACQUIRE;
            req.slot_index = 2'(sat_slot);
            req.generation = frm_gen[sat_slot];
            sat_acq--;
        end else if (sat_rel > 0 && sat_slot >= 0) begin
            req.mode = MODE_RELEASE;
            req.slot_index = 2'(sat_slot);
            sat_rel--;
        end else if (roll < 8) begin
            // leave every field random
        end else if (roll < 32) begin
            req.mode = MODE_RESERVE;
            if ($urandom_range(0, 4) != 0) begin
                req.width = 12'($urandom_range(1, lim_width));
                req.height = $urandom_range(0, 1) ? 12'($urandom_range(1, 8))
                                                  : 12'($urandom_range(1, lim_height));
                req.stride = 13'(req.width) + 13'($urandom_range(0, 3));
            end
        end else if (roll < 52) begin
            req.mode = MODE_COMMIT;
            pick = find_slot(PH_WRITING, 1'b0);
        end else if (roll < 58) begin
            req.mode = MODE_ABORT;
            pick = find_slot(PH_WRITING, 1'b0);
        end else if (roll < 72) begin
            req.mode = MODE_ACQUIRE;
            pick = find_slot(PH_READY, 1'b0);
        end else if (roll < 82) begin
            req.mode = MODE_LATEST;
            case ($urandom_range(0, 3))
                0: req.frame_num = pub_frame;
                1: req.frame_num = '0;
                default: ;
            endcase
        end else begin
            req.mode = MODE_RELEASE;
            pick = find_slot(PH_FREE, 1'b1);
        end
        if (pick >= 0 && $urandom_range(0, 6) != 0) begin
            req.slot_index = 2'(pick);
            req.generation = frm_gen[pick];
        end
        return req;
    endfunction

    // sender: predicts each transfer, then offers the next request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                predicted = apply_request(i_in_data);
                if (cur_row.typed) begin
                    predicted.status         = cur_row.sts;
                    predicted.slot_out       = cur_row.slot;
                    predicted.generation_out = cur_row.gen;
                    predicted.dropped_total  = cur_row.drops;
                end
                pending_results.push_back(predicted);
            end
            if (!i_in_valid || o_in_ready) begin
                if (!hold_src && $urandom_range(0, 99) >= src_idle_pct
                    && (req_q.size() != 0 || rand_left > 0)) begin
                    if (req_q.size() != 0) begin
                        cur_row = req_q.pop_front();
                    end else begin
                        cur_row.typed = 1'b0;
                        cur_row.req = make_request();
                        rand_left--;
                    end
                    i_in_data <= cur_row.req;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
        if (exp_v !== got_v) begin
            $display("%0t: %s expected %0h got %0h", $time, name, exp_v, got_v);
            error_cnt++;
        end
    endtask

    // receiver: checks each transfer against the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: result expected none got %0h", $time, o_out_data);
                    error_cnt++;
                end else begin
                    want = pending_results.pop_front();
                    compare_field("status", want.status, o_out_data.status);
                    compare_field("slot_out", want.slot_out, o_out_data.slot_out);
                    compare_field("generation_out", want.generation_out,
                                  o_out_data.generation_out);
                    compare_field("frame_num_out", want.frame_num_out,
                                  o_out_data.frame_num_out);
                    compare_field("capture_time_out", want.capture_time_out,
                                  o_out_data.capture_time_out);
                    compare_field("width_out", want.width_out, o_out_data.width_out);
                    compare_field("height_out", want.height_out, o_out_data.height_out);
                    compare_field("stride_out", want.stride_out, o_out_data.stride_out);
                    compare_field("dropped_total", want.dropped_total,
                                  o_out_data.dropped_total);
                    compare_field("overwritten_total", want.overwritten_total,
                                  o_out_data.overwritten_total);
                    compare_field("submitted_total", want.submitted_total,
                                  o_out_data.submitted_total);
                end
            end
            i_out_ready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("** frame_slot_manager_top: FAILED **");
        $finish;
    end

    task automatic wait_all_done();
        while (req_q.size() != 0 || rand_left != 0 || i_in_valid
               || pending_results.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic set_limit(t_cfg_reg which, logic [CfgDataW-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= which;
        i_cfg_data <= val;
        case (which)
            CFG_MAX_WIDTH:  lim_width = val[11:0];
            CFG_MAX_HEIGHT: lim_height = val[11:0];
            CFG_MAX_BYTES:  lim_bytes = val[23:0];
            default: ;
        endcase
    endtask

    initial begin
        int half;
        for (int s = 0; s < SlotCount; s++) begin
            frm_phase[s]   = PH_FREE;
            frm_gen[s]     = '0;
            frm_readers[s] = '0;
            frm_id[s]      = '0;
            frm_time[s]    = '0;
            frm_w[s]       = '0;
            frm_h[s]       = '0;
            frm_stride[s]  = '0;
        end
        scan_start    = 0;
        pub_valid     = 1'b0;
        pub_slot      = 0;
        pub_gen       = '0;
        pub_frame     = '0;
        n_dropped     = '0;
        n_overwritten = '0;
        n_submitted   = '0;
        lim_width     = 12'd640;
        lim_height    = 12'd480;
        lim_bytes     = 24'd307200;

        // request, then typed status, slot, generation and drop count where checked
        directed_rows = '{
            '{'{MODE_RESERVE, 0, 0, 0, 0, 0, 1, 1}, 1, STS_BAD_GEOM, 0, 0, 1},
            '{'{MODE_LATEST, 0, 0, 5, 0, 0, 0, 0}, 1, STS_NOTHING_NEW, 0, 0, 1},
            '{'{MODE_RESERVE, 0, 0, 0, 0, 640, 480, 640}, 1, STS_OK, 0, 1, 1},
            '{'{MODE_RESERVE, 3, 'hFFFF_FFFF, 'hFFFF_FFFF, 'hFFFF_FFFF, 4095, 4095, 8191},
              1, STS_BAD_GEOM, 0, 0, 2},
            '{'{MODE_RESERVE, 0, 0, 0, 0, 10, 481, 10}, 1, STS_BAD_GEOM, 0, 0, 3},
            '{'{MODE_RESERVE, 0, 0, 0, 0, 640, 480, 641}, 1, STS_BAD_GEOM, 0, 0, 4},
            '{'{MODE_RESERVE, 0, 0, 0, 0, 20, 2, 19}, 1, STS_BAD_GEOM, 0, 0, 5},
            '{'{MODE_COMMIT, 0, 1, 'hFFFF_FFFF, 'hFFFF_FFFF, 0, 0, 0}, 0, STS_OK, 0, 0, 0},
            '{'{MODE_COMMIT, 0, 1, 5, 6, 0, 0, 0}, 1, STS_STALE, 0, 0, 6},
            '{'{MODE_COMMIT, 3, 1, 0, 0, 0, 0, 0}, 1, STS_INVALID, 0, 0, 6},
            '{'{MODE_ACQUIRE, 0, 1, 0, 0, 0, 0, 0}, 0, STS_OK, 0, 0, 0},
            '{'{MODE_LATEST, 0, 0, 'hFFFF_FFFF, 0, 0, 0, 0}, 1, STS_NOTHING_NEW, 0, 0, 6},
            '{'{MODE_LATEST, 0, 0, 0, 0, 0, 0, 0}, 0, STS_OK, 0, 0, 0},
            '{'{MODE_RESERVE, 0, 0, 0, 0, 1, 1, 1}, 0, STS_OK, 0, 0, 0},
            '{'{MODE_RESERVE, 0, 0, 0, 0, 1, 1, 8191}, 0, STS_OK, 0, 0, 0},
            '{'{MODE_RESERVE, 0, 0, 0, 0, 8, 8, 8}, 1, STS_NO_SLOT, 0, 0, 7},
            '{'{MODE_ABORT, 1, 5, 0, 0, 0, 0, 0}, 1, STS_INVALID, 0, 0, 7},
            '{'{MODE_ABORT, 1, 1, 0, 0, 0, 0, 0}, 0, STS_OK, 0, 0, 0},
            '{'{MODE_RELEASE, 0, 0, 0, 0, 0, 0, 0}, 0, STS_OK, 0, 0, 0},
            '{'{MODE_RELEASE, 0, 0, 0, 0, 0, 0, 0}, 0, STS_OK, 0, 0, 0},
            '{'{MODE_RELEASE, 0, 0, 0, 0, 0, 0, 0}, 1, STS_INVALID, 0, 0, 7},
            '{'{MODE_RELEASE, 3, 0, 0, 0, 0, 0, 0}, 1, STS_INVALID, 0, 0, 7},
            '{'{MODE_ACQUIRE, 2, 1, 0, 0, 0, 0, 0}, 1, STS_INVALID, 0, 0, 7},
            '{'{MODE_SPARE_A, 0, 0, 0, 0, 0, 0, 0}, 1, STS_INVALID, 0, 0, 7},
            '{'{MODE_SPARE_B, 0, 0, 0, 0, 0, 0, 0}, 1, STS_INVALID, 0, 0, 7},
            // ready slot 0 gets reclaimed, so the published frame goes stale
            '{'{MODE_RESERVE, 0, 0, 0, 0, 1, 1, 1}, 0, STS_OK, 0, 0, 0},
            '{'{MODE_LATEST, 0, 0, 0, 0, 0, 0, 0}, 1, STS_INVALID, 0, 0, 7}
        };

        segs = '{
            '{34, 62, 4095, 4095, 'hFF_FFFF, 250, 1'b0},
            '{34, 62, 1, 1, 1, 100, 1'b0},
            '{62, 34, 200, 64, 4000, 300, 1'b0},
            '{62, 34, 640, 480, 307200, 200, 1'b0},
            '{0, 0, 64, 4095, 'hFF_FFFF, 150, 1'b1},
            '{0, 0, 4095, 1, 8191, 150, 1'b0}
        };

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        src_idle_pct = segs[0].src_pct;
        snk_idle_pct = segs[0].snk_pct;
        for (int r = 0; r < DIR_ROWS; r++)
            req_q.push_back(directed_rows[r]);

        for (int k = 0; k < SEGMENTS; k++) begin
            wait_all_done();
            repeat (4) @(posedge i_clk);
            set_limit(CFG_MAX_WIDTH, CfgDataW'(segs[k].max_w));
            set_limit(CFG_MAX_HEIGHT, CfgDataW'(segs[k].max_h));
            set_limit(CFG_MAX_BYTES, CfgDataW'(segs[k].max_b));
            @(posedge i_clk);
            i_cfg_we <= 1'b0;
            @(negedge i_clk);
            src_idle_pct = segs[k].src_pct;
            snk_idle_pct = segs[k].snk_pct;
            if (segs[k].saturate) begin
                // pile readers onto one frame past the counter ceiling, then unwind
                sat_slot = -1;
                sat_acq = SAT_ACQUIRES;
                sat_rel = SAT_RELEASES;
                rand_left = segs[k].items + SAT_ACQUIRES + SAT_RELEASES;
            end else begin
                rand_left = segs[k].items;
            end
            half = rand_left / 2;
            while (rand_left > half)
                @(negedge i_clk);
            // hold off the sender until every pending result is back
            hold_src = 1'b1;
            while (i_in_valid || pending_results.size() != 0)
                @(negedge i_clk);
            hold_src = 1'b0;
        end

        wait_all_done();
        repeat (10) @(posedge i_clk);
        if (error_cnt == 0)
            $display("** frame_slot_manager_top: PASSED **");
        else
            $display("** frame_slot_manager_top: FAILED **");
        $finish;
    end

endmodule
